/* rtl/mlr_pkg.sv */
// shared constants and types for the midpoint line rasterizer
`default_nettype none

package mlr_pkg;

  localparam int CoordBits = 6;
  localparam int FieldBits = 6;
  localparam int InDataW   = 4 * FieldBits;
  localparam int OutDataW  = 16;
  localparam int OutPadW   = OutDataW - 2 * FieldBits;

  typedef enum logic [2:0] {
    MODE_VERT         = 3'd0,
    MODE_SHALLOW_UP   = 3'd1,
    MODE_SHALLOW_DOWN = 3'd2,
    MODE_STEEP_UP     = 3'd3,
    MODE_STEEP_DOWN   = 3'd4
  } mode_e;

endpackage

`default_nettype wire

/* rtl/mlr_setup.sv */
// endpoint ordering, delta and octant setup for one line request
`default_nettype none

module mlr_setup #(
  parameter int CoordBits = mlr_pkg::CoordBits,
  parameter int DecW      = CoordBits + 3
) (
  input  wire logic [CoordBits-1:0]   x_start_i,
  input  wire logic [CoordBits-1:0]   y_start_i,
  input  wire logic [CoordBits-1:0]   x_end_i,
  input  wire logic [CoordBits-1:0]   y_end_i,
  output logic      [CoordBits-1:0]   start_x_o,
  output logic      [CoordBits-1:0]   start_y_o,
  output logic      [CoordBits-1:0]   steps_o,
  output mlr_pkg::mode_e              mode_o,
  output logic signed [DecW-1:0]      dec_o,
  output logic signed [DecW-1:0]      inc_keep_o,
  output logic signed [DecW-1:0]      inc_take_o
);
  import mlr_pkg::*;

  logic                  swap;
  logic [CoordBits-1:0]  ax, ay, bx, by;
  logic [CoordBits-1:0]  dx, dy;
  logic                  rising;
  logic signed [DecW-1:0] dx_s, dy_s, major_s, minor_s;

  always_comb begin
    swap = (x_start_i > x_end_i) || ((x_start_i == x_end_i) && (y_start_i > y_end_i));
    ax = swap ? x_end_i   : x_start_i;
    ay = swap ? y_end_i   : y_start_i;
    bx = swap ? x_start_i : x_end_i;
    by = swap ? y_start_i : y_end_i;
    dx = bx - ax;
    rising = (by >= ay);
    dy = rising ? (by - ay) : (ay - by);
    dx_s = $signed(DecW'(dx));
    dy_s = $signed(DecW'(dy));

    if (dx == '0) begin
      mode_o  = MODE_VERT;
      major_s = dy_s;
      minor_s = '0;
      dec_o   = -dy_s;
      steps_o = dy;
    end else if (dy <= dx) begin
      mode_o  = rising ? MODE_SHALLOW_UP : MODE_SHALLOW_DOWN;
      major_s = dx_s;
      minor_s = dy_s;
      dec_o   = dy_s + dy_s - dx_s;
      steps_o = dx;
    end else begin
      mode_o  = rising ? MODE_STEEP_UP : MODE_STEEP_DOWN;
      major_s = dy_s;
      minor_s = dx_s;
      dec_o   = dx_s + dx_s - dy_s;
      steps_o = dy;
    end

    inc_keep_o = minor_s + minor_s;
    inc_take_o = (minor_s - major_s) + (minor_s - major_s);
    start_x_o  = ax;
    start_y_o  = ay;
  end

endmodule

`default_nettype wire

/* rtl/mlr_step.sv */
// shared step unit: midpoint decision update and coordinate advance
`default_nettype none

module mlr_step #(
  parameter int CoordBits = mlr_pkg::CoordBits,
  parameter int DecW      = CoordBits + 3
) (
  input  wire mlr_pkg::mode_e         mode_i,
  input  wire logic signed [DecW-1:0] dec_i,
  input  wire logic signed [DecW-1:0] inc_keep_i,
  input  wire logic signed [DecW-1:0] inc_take_i,
  input  wire logic [CoordBits-1:0]   cur_x_i,
  input  wire logic [CoordBits-1:0]   cur_y_i,
  output logic signed [DecW-1:0]      dec_o,
  output logic [CoordBits-1:0]        cur_x_o,
  output logic [CoordBits-1:0]        cur_y_o
);
  import mlr_pkg::*;

  logic take_minor;
  logic dec_pos, dec_neg;

  always_comb begin
    dec_neg = dec_i[DecW-1];
    dec_pos = !dec_neg && (dec_i != '0);
    case (mode_i)
      MODE_VERT:     take_minor = 1'b0;
      MODE_STEEP_UP: take_minor = !dec_neg;
      default:       take_minor = dec_pos;
    endcase

    dec_o   = dec_i + (take_minor ? inc_take_i : inc_keep_i);
    cur_x_o = cur_x_i;
    cur_y_o = cur_y_i;
    case (mode_i)
      MODE_VERT: begin
        cur_y_o = cur_y_i + 1'b1;
      end
      MODE_SHALLOW_UP: begin
        cur_x_o = cur_x_i + 1'b1;
        if (take_minor) cur_y_o = cur_y_i + 1'b1;
      end
      MODE_SHALLOW_DOWN: begin
        cur_x_o = cur_x_i + 1'b1;
        if (take_minor) cur_y_o = cur_y_i - 1'b1;
      end
      MODE_STEEP_UP: begin
        cur_y_o = cur_y_i + 1'b1;
        if (take_minor) cur_x_o = cur_x_i + 1'b1;
      end
      default: begin
        cur_y_o = cur_y_i - 1'b1;
        if (take_minor) cur_x_o = cur_x_i + 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/midpoint_line_rasterizer.sv */
// top level of the midpoint line rasterizer
// A line request (x_start, y_start, x_end, y_end) is taken while the block is idle; the setup
// is done in the cycle of the transaction, then one pixel a cycle is presented on the master
// side while the sink is ready (a stall holds the current pixel), walked by the shared
// decision/step unit, so a line of major delta n yields n pixels. The far endpoint is
// not drawn, a zero-length line emits no pixel, and tlast marks the final pixel of each line.
// Coordinates are taken modulo 2^COORD_BITS.
`default_nettype none

module midpoint_line_rasterizer #(
  parameter int COORD_BITS = mlr_pkg::CoordBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
  input  wire logic [mlr_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pixel_x[5:0], pixel_y[11:6], zero[15:12]
  output logic [mlr_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast
);
  import mlr_pkg::*;

  localparam int DecW = COORD_BITS + 3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [COORD_BITS-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]   steps_q, steps_d;
  mode_e                   mode_q, mode_d;
  logic signed [DecW-1:0]  dec_q, dec_d;
  logic signed [DecW-1:0]  inc_keep_q, inc_keep_d, inc_take_q, inc_take_d;

  logic [COORD_BITS-1:0]   in_x0, in_y0, in_x1, in_y1;
  logic [COORD_BITS-1:0]   su_x, su_y, su_steps;
  mode_e                   su_mode;
  logic signed [DecW-1:0]  su_dec, su_keep, su_take;
  logic signed [DecW-1:0]  st_dec;
  logic [COORD_BITS-1:0]   st_x, st_y;
  logic                    in_fire, out_fire;
  logic [FieldBits-1:0]    px, py;

  assign in_x0 = s_axis_tdata[COORD_BITS-1:0];
  assign in_y0 = s_axis_tdata[FieldBits+COORD_BITS-1:FieldBits];
  assign in_x1 = s_axis_tdata[2*FieldBits+COORD_BITS-1:2*FieldBits];
  assign in_y1 = s_axis_tdata[3*FieldBits+COORD_BITS-1:3*FieldBits];

  mlr_setup #(
    .CoordBits (COORD_BITS),
    .DecW      (DecW)
  ) u_setup (
    .x_start_i  (in_x0),
    .y_start_i  (in_y0),
    .x_end_i    (in_x1),
    .y_end_i    (in_y1),
    .start_x_o  (su_x),
    .start_y_o  (su_y),
    .steps_o    (su_steps),
    .mode_o     (su_mode),
    .dec_o      (su_dec),
    .inc_keep_o (su_keep),
    .inc_take_o (su_take)
  );

  mlr_step #(
    .CoordBits (COORD_BITS),
    .DecW      (DecW)
  ) u_step (
    .mode_i     (mode_q),
    .dec_i      (dec_q),
    .inc_keep_i (inc_keep_q),
    .inc_take_i (inc_take_q),
    .cur_x_i    (cur_x_q),
    .cur_y_i    (cur_y_q),
    .dec_o      (st_dec),
    .cur_x_o    (st_x),
    .cur_y_o    (st_y)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_WALK);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign px           = FieldBits'(cur_x_q);
  assign py           = FieldBits'(cur_y_q);
  assign m_axis_tdata = {{OutPadW{1'b0}}, py, px};
  assign m_axis_tlast = (steps_q == COORD_BITS'(1));

  always_comb begin
    state_d    = state_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    steps_d    = steps_q;
    mode_d     = mode_q;
    dec_d      = dec_q;
    inc_keep_d = inc_keep_q;
    inc_take_d = inc_take_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cur_x_d    = su_x;
          cur_y_d    = su_y;
          steps_d    = su_steps;
          mode_d     = su_mode;
          dec_d      = su_dec;
          inc_keep_d = su_keep;
          inc_take_d = su_take;
          if (su_steps != '0) state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_fire) begin
          cur_x_d = st_x;
          cur_y_d = st_y;
          dec_d   = st_dec;
          steps_d = steps_q - 1'b1;
          if (m_axis_tlast) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      steps_q    <= '0;
      mode_q     <= MODE_VERT;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      dec_q      <= '0;
      inc_keep_q <= '0;
      inc_take_q <= '0;
    end else begin
      state_q    <= state_d;
      steps_q    <= steps_d;
      mode_q     <= mode_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      dec_q      <= dec_d;
      inc_keep_q <= inc_keep_d;
      inc_take_q <= inc_take_d;
    end
  end

endmodule

`default_nettype wire

/* test/midpoint_line_rasterizer_tb.sv */
// testbench for the midpoint line rasterizer: random line requests checked pixel by pixel
`timescale 1ns / 100ps

module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  typedef struct {
    logic [5:0] x_start;
    logic [5:0] y_start;
    logic [5:0] x_end;
    logic [5:0] y_end;
    bit         drain;
  } line_req_t;

  typedef struct {
    logic [5:0] x;
    logic [5:0] y;
    logic       last;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // x_start, y_start, x_end, y_end
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // pixel_x, pixel_y, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  line_req_t pending_lines[$];
  pixel_t    pixel_q[$];
  line_req_t offered;
  int        total_lines;
  int        lines_accepted = 0;
  int        pixels_predicted = 0;
  int        pixels_checked = 0;
  int        mismatch_count = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  midpoint_line_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void add_line(int xs, int ys, int xe, int ye, bit drain = 1'b0);
    line_req_t r;
    r.x_start = xs[5:0];
    r.y_start = ys[5:0];
    r.x_end   = xe[5:0];
    r.y_end   = ye[5:0];
    r.drain   = drain;
    pending_lines.push_back(r);
  endfunction

  // idle bursts in alternating stretches of 40 lines, none in the tail
  function automatic bit idle_on();
    return (lines_accepted < total_lines - 40) && ((lines_accepted / 40) % 2 == 0);
  endfunction

  // walks one line and queues its expected pixels, returns the pixel count
  function automatic int trace_line(line_req_t r);
    logic [5:0] ax, ay, bx, by, px, py, t;
    int         dx, dy, major, minor, dec, steps, n;
    bit         up, step_minor;
    mode_e      mode;
    pixel_t     p;
    ax = r.x_start;
    ay = r.y_start;
    bx = r.x_end;
    by = r.y_end;
    n = 0;
    if (ax > bx || (ax == bx && ay > by)) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = int'(bx) - int'(ax);
    dy = int'(by) - int'(ay);
    up = dy >= 0;
    if (dy < 0) dy = -dy;
    px = ax;
    py = ay;
    if (dx == 0) begin
      mode = MODE_VERT;
      major = dy;
      minor = 0;
      dec = -dy;
    end else if (dy <= dx) begin
      mode = up ? MODE_SHALLOW_UP : MODE_SHALLOW_DOWN;
      major = dx;
      minor = dy;
      dec = 2 * dy - dx;
    end else begin
      mode = up ? MODE_STEEP_UP : MODE_STEEP_DOWN;
      major = dy;
      minor = dx;
      dec = 2 * dx - dy;
    end
    for (steps = major; steps > 0; steps--) begin
      p.x = px;
      p.y = py;
      p.last = (steps == 1);
      pixel_q.push_back(p);
      n++;
      case (mode)
        MODE_VERT:     step_minor = 1'b0;
        MODE_STEEP_UP: step_minor = dec >= 0;
        default:       step_minor = dec > 0;
      endcase
      dec += step_minor ? 2 * (minor - major) : 2 * minor;
      case (mode)
        MODE_VERT: py = py + 6'd1;
        MODE_SHALLOW_UP: begin
          px = px + 6'd1;
          if (step_minor) py = py + 6'd1;
        end
        MODE_SHALLOW_DOWN: begin
          px = px + 6'd1;
          if (step_minor) py = py - 6'd1;
        end
        MODE_STEEP_UP: begin
          py = py + 6'd1;
          if (step_minor) px = px + 6'd1;
        end
        default: begin
          py = py - 6'd1;
          if (step_minor) px = px + 6'd1;
        end
      endcase
    end
    return n;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pixels_predicted <= pixels_predicted + trace_line(offered);
        lines_accepted <= lines_accepted + 1;
        if (idle_on() && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_lines.size() != 0 &&
                   !(pending_lines[0].drain &&
                     ((s_axis_tvalid && s_axis_tready) ||
                      pixels_checked != pixels_predicted))) begin
        offered = pending_lines.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {offered.y_end, offered.x_end, offered.y_start, offered.x_start};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // pixel monitor and sink
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                    m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tlast));
        end else begin
          e = pixel_q.pop_front();
          pixels_checked <= pixels_checked + 1;
          if (m_axis_tdata[5:0] !== e.x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d", m_axis_tdata[5:0], e.x));
          if (m_axis_tdata[11:6] !== e.y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d", m_axis_tdata[11:6], e.y));
          if (m_axis_tdata[OutDataW-1:12] !== '0)
            report_mismatch($sformatf("pad bits %0h, expected 0", m_axis_tdata[OutDataW-1:12]));
          if (m_axis_tlast !== e.last)
            report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast, e.last));
        end
      end
      if (!hold_done && lines_accepted >= 60) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int kind, xs, ys, xe, ye, d;
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    add_line(5, 0, 5, 63);
    add_line(63, 63, 63, 0);
    add_line(0, 0, 63, 0);
    add_line(63, 10, 0, 10);
    add_line(0, 0, 63, 63);
    add_line(0, 63, 63, 0);
    add_line(63, 0, 0, 63);
    add_line(0, 0, 63, 20);
    add_line(3, 50, 60, 7);
    add_line(60, 7, 3, 50);
    add_line(10, 0, 20, 63);
    add_line(0, 63, 1, 0);
    add_line(40, 2, 30, 61);
    add_line(7, 7, 8, 7);
    add_line(7, 7, 7, 8);
    add_line(7, 8, 8, 7);
    add_line(8, 7, 7, 8);
    add_line(21, 42, 42, 21);
    add_line(42, 21, 21, 42, 1'b1);
    add_line(63, 0, 62, 63);
    for (int i = 0; i < 290; i++) begin
      kind = $urandom_range(0, 19);
      xs = $urandom_range(0, 63);
      ys = $urandom_range(0, 63);
      xe = $urandom_range(0, 63);
      ye = $urandom_range(0, 63);
      d = $urandom_range(1, 63);
      case (kind)
        11, 12, 13: begin
          xe = xs + $urandom_range(0, 6) - 3;
          ye = ys + $urandom_range(0, 6) - 3;
        end
        14: xe = xs;
        15: ye = ys;
        16, 17: begin
          xs = $urandom_range(0, 63 - d);
          xe = xs + d;
          if ($urandom_range(0, 1)) begin
            ys = $urandom_range(0, 63 - d);
            ye = ys + d;
          end else begin
            ys = $urandom_range(d, 63);
            ye = ys - d;
          end
        end
        18: begin
          xe = xs;
          ye = ys;
        end
        19: begin
          xe = xs + $urandom_range(0, 3);
          ys = $urandom_range(32, 63);
          ye = $urandom_range(0, 27);
        end
        default: ;
      endcase
      add_line(xs, ys, xe, ye, i == 100 || i == 200);
    end
    total_lines = pending_lines.size();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (lines_accepted != total_lines) @(posedge clk_i);
    while (pixels_checked != pixels_predicted) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (pixel_q.size() != 0)
      report_mismatch($sformatf("%0d expected pixels never arrived", pixel_q.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
